@@ rtl/zsre_pkg.sv @@
`timescale 1ns / 1ps

package zsre_pkg;

    localparam int TICK_W   = 32;
    localparam int ID_W     = 8;
    localparam int OFS_W    = 6;
    localparam int FUNC_W   = 2;
    localparam int STAT_W   = 2;
    localparam int ZSEL_W   = 2;
    localparam int LEN_W    = 2;
    localparam int CFG_IX_W = 1;

    localparam logic [ID_W-1:0] EMPTY_ID = 8'hFF;

    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RESERVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_GRANTED  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_REFUSED  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RELEASED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_TICKED   = 2'd3;

    localparam logic [CFG_IX_W-1:0] CFG_EARLIEST = 1'b0;
    localparam logic [CFG_IX_W-1:0] CFG_LATEST   = 1'b1;

    localparam logic [OFS_W-1:0] EARLIEST_RST = 6'd6;
    localparam logic [OFS_W-1:0] LATEST_RST   = 6'd10;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REL_SCAN,
        ST_REL_DRAIN,
        ST_RES_INIT,
        ST_RES_NORM,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_CLAIM,
        ST_RESULT
    } t_state;

endpackage

@@ rtl/zsre_ram.sv @@
`timescale 1ns / 1ps

module zsre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/zone_slot_reservation_engine_top.sv @@
`timescale 1ns / 1ps

// Zone slot reservation engine.
// Input channel (i_valid / o_stall) takes one transaction: a tick, a reserve
// of a route of one to three zones, or a release of an owner id. Output
// channel (o_valid / i_stall) returns one result transaction per item; an
// unused function code is dropped with no result. One item at a time.
// Flow, accept to result valid: a tick goes straight to the result. A release
// scans the table, one entry a cycle, and clears each entry that holds the id.
// A reserve checks the window, then normalizes the slot (subtracting SLOT_COUNT
// until below it; when the first entry time wraps past 2^32 the wrapped time
// gives the slot), then probes 2 slots per zone per candidate offset, through
// a read state and a check state for each slot, and then makes 2*route_length
// claim writes; the single table read port serializes these steps.
// After reset the table is swept to empty with o_stall high; configuration
// writes are taken throughout. While the receiver stalls, the result holds and
// no new transaction is accepted. Configuration is to be written only while the
// block is idle; the block itself does not enforce this.
module zone_slot_reservation_engine_top #(
    parameter int SLOT_COUNT = 64,
    parameter int ZONE_COUNT = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [zsre_pkg::CFG_IX_W-1:0]     i_cfg_index,
    input  logic [zsre_pkg::OFS_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [zsre_pkg::FUNC_W-1:0]       i_func,
    input  logic [zsre_pkg::ID_W-1:0]         i_vehicle_id,
    input  logic [zsre_pkg::LEN_W-1:0]        i_route_length,
    input  logic [zsre_pkg::ZSEL_W-1:0]       i_zone_first,
    input  logic [zsre_pkg::ZSEL_W-1:0]       i_zone_second,
    input  logic [zsre_pkg::ZSEL_W-1:0]       i_zone_third,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [zsre_pkg::STAT_W-1:0]       o_status,
    output logic [zsre_pkg::TICK_W-1:0]       o_entry_tick,
    output logic [zsre_pkg::OFS_W-1:0]        o_approach_ticks,
    output logic [zsre_pkg::OFS_W-1:0]        o_slack_ticks,
    output logic                              o_speed_mode
);

    localparam int TOTAL = ZONE_COUNT * SLOT_COUNT;
    localparam int AW    = $clog2(TOTAL);
    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int ZW    = $clog2(ZONE_COUNT);
    localparam int CW    = $clog2(SLOT_COUNT + 64);
    localparam int TW    = zsre_pkg::TICK_W;
    localparam int OW    = zsre_pkg::OFS_W;
    localparam int IW    = zsre_pkg::ID_W;

    localparam logic [AW-1:0] LAST_ADDR   = AW'(TOTAL - 1);
    localparam logic [AW-1:0] SLOTS_A     = AW'(SLOT_COUNT);
    localparam logic [SW-1:0] LAST_SLOT   = SW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0] SLOTS_C     = CW'(SLOT_COUNT);
    localparam logic [4:0]    ZONES_5     = 5'(ZONE_COUNT);

    zsre_pkg::t_state r_state, n_state;

    logic [TW-1:0]                  r_tick, n_tick;
    logic [SW-1:0]                  r_tick_slot, n_tick_slot;
    logic [OW-1:0]                  r_earliest, r_latest;
    logic [IW-1:0]                  r_id, n_id;
    logic [zsre_pkg::LEN_W-1:0]     r_len, n_len;
    logic [ZW-1:0]                  r_zone0, n_zone0, r_zone1, n_zone1, r_zone2, n_zone2;
    logic [OW-1:0]                  r_k, n_k;
    logic [TW-1:0]                  r_cand_t, n_cand_t;
    logic [CW-1:0]                  r_cand_slot, n_cand_slot;
    logic [TW-1:0]                  r_walk_t, n_walk_t;
    logic [SW-1:0]                  r_walk_slot, n_walk_slot;
    logic [2:0]                     r_j, n_j;
    logic [AW-1:0]                  r_addr, n_addr;
    logic                           r_rd_pend, n_rd_pend;
    logic [AW-1:0]                  r_rd_addr, n_rd_addr;
    logic [zsre_pkg::STAT_W-1:0]    r_status, n_status;
    logic [TW-1:0]                  r_entry, n_entry;
    logic [OW-1:0]                  r_appr, n_appr;
    logic [OW-1:0]                  r_slack, n_slack;
    logic                           r_speed, n_speed;

    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [IW-1:0]   w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [IW-1:0]   w_rdata;

    logic            w_accept;
    logic            w_scan_last;
    logic            w_window_bad;
    logic            w_norm_done;
    logic            w_slot_busy;
    logic            w_k_last;
    logic            w_j_last;
    logic            w_rel_hit;
    logic [ZW-1:0]   w_zone_cur;
    logic [AW-1:0]   w_slot_addr;
    logic [SW-1:0]   w_walk_step;
    logic [SW-1:0]   w_cand_step;
    logic [TW:0]     w_start_sum;

    function automatic logic [ZW-1:0] fold_zone(input logic [zsre_pkg::ZSEL_W-1:0] z);
        logic [4:0] zz;
        zz = 5'(z);
        if (zz >= ZONES_5) begin
            zz = zz - ZONES_5;
        end
        return ZW'(zz);
    endfunction

    function automatic logic [SW-1:0] step_slot(input logic [SW-1:0] s, input logic [TW-1:0] t);
        logic [SW-1:0] ns;
        if (t == '1) begin
            ns = '0;
        end else if (s == LAST_SLOT) begin
            ns = '0;
        end else begin
            ns = s + SW'(1);
        end
        return ns;
    endfunction

    zsre_ram #(
        .WIDTH (IW),
        .DEPTH (TOTAL)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_accept     = i_valid && !o_stall;
    assign w_scan_last  = (r_addr == LAST_ADDR);
    assign w_window_bad = (r_earliest > r_latest) || (r_len == '0);
    assign w_norm_done  = (r_cand_slot < SLOTS_C);
    assign w_slot_busy  = (w_rdata != zsre_pkg::EMPTY_ID);
    assign w_k_last     = (r_k == r_latest);
    assign w_j_last     = (r_j == (3'({r_len, 1'b0}) - 3'd1));
    assign w_rel_hit    = r_rd_pend && (w_rdata == r_id);
    assign w_zone_cur   = (r_j[2:1] == 2'd2) ? r_zone2 : (r_j[1] ? r_zone1 : r_zone0);
    assign w_slot_addr  = AW'(w_zone_cur) * SLOTS_A + AW'(r_walk_slot);
    assign w_walk_step  = step_slot(r_walk_slot, r_walk_t);
    assign w_cand_step  = step_slot(SW'(r_cand_slot), r_cand_t);
    assign w_start_sum  = {1'b0, r_tick} + (TW+1)'(r_earliest);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            zsre_pkg::ST_CLEAR: begin
                if (w_scan_last) n_state = zsre_pkg::ST_IDLE;
            end
            zsre_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_func)
                        zsre_pkg::FUNC_TICK:    n_state = zsre_pkg::ST_RESULT;
                        zsre_pkg::FUNC_RESERVE: n_state = zsre_pkg::ST_RES_INIT;
                        zsre_pkg::FUNC_RELEASE: n_state = zsre_pkg::ST_REL_SCAN;
                        default:                n_state = zsre_pkg::ST_IDLE;
                    endcase
                end
            end
            zsre_pkg::ST_REL_SCAN: begin
                if (w_scan_last) n_state = zsre_pkg::ST_REL_DRAIN;
            end
            zsre_pkg::ST_REL_DRAIN: n_state = zsre_pkg::ST_RESULT;
            zsre_pkg::ST_RES_INIT: begin
                n_state = w_window_bad ? zsre_pkg::ST_RESULT : zsre_pkg::ST_RES_NORM;
            end
            zsre_pkg::ST_RES_NORM: begin
                if (w_norm_done) n_state = zsre_pkg::ST_PROBE_RD;
            end
            zsre_pkg::ST_PROBE_RD: n_state = zsre_pkg::ST_PROBE_CHK;
            zsre_pkg::ST_PROBE_CHK: begin
                if (w_slot_busy) begin
                    n_state = w_k_last ? zsre_pkg::ST_RESULT : zsre_pkg::ST_PROBE_RD;
                end else begin
                    n_state = w_j_last ? zsre_pkg::ST_CLAIM : zsre_pkg::ST_PROBE_RD;
                end
            end
            zsre_pkg::ST_CLAIM: begin
                if (w_j_last) n_state = zsre_pkg::ST_RESULT;
            end
            zsre_pkg::ST_RESULT: begin
                if (!i_stall) n_state = zsre_pkg::ST_IDLE;
            end
            default: n_state = zsre_pkg::ST_IDLE;
        endcase
    end

    // outputs and table port
    always_comb begin
        o_stall = (r_state != zsre_pkg::ST_IDLE);
        o_valid = (r_state == zsre_pkg::ST_RESULT);
        w_we    = 1'b0;
        w_waddr = r_rd_addr;
        w_wdata = zsre_pkg::EMPTY_ID;
        w_raddr = w_slot_addr;
        unique case (r_state)
            zsre_pkg::ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
            end
            zsre_pkg::ST_REL_SCAN: begin
                w_we    = w_rel_hit;
                w_raddr = r_addr;
            end
            zsre_pkg::ST_REL_DRAIN: begin
                w_we = w_rel_hit;
            end
            zsre_pkg::ST_CLAIM: begin
                w_we    = 1'b1;
                w_waddr = w_slot_addr;
                w_wdata = r_id;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_tick      = r_tick;
        n_tick_slot = r_tick_slot;
        n_id        = r_id;
        n_len       = r_len;
        n_zone0     = r_zone0;
        n_zone1     = r_zone1;
        n_zone2     = r_zone2;
        n_k         = r_k;
        n_cand_t    = r_cand_t;
        n_cand_slot = r_cand_slot;
        n_walk_t    = r_walk_t;
        n_walk_slot = r_walk_slot;
        n_j         = r_j;
        n_addr      = r_addr;
        n_rd_pend   = 1'b0;
        n_rd_addr   = r_rd_addr;
        n_status    = r_status;
        n_entry     = r_entry;
        n_appr      = r_appr;
        n_slack     = r_slack;
        n_speed     = r_speed;
        unique case (r_state)
            zsre_pkg::ST_CLEAR: begin
                n_addr = r_addr + AW'(1);
            end
            zsre_pkg::ST_IDLE: begin
                n_id     = i_vehicle_id;
                n_len    = i_route_length;
                n_zone0  = fold_zone(i_zone_first);
                n_zone1  = fold_zone(i_zone_second);
                n_zone2  = fold_zone(i_zone_third);
                n_addr   = '0;
                n_entry  = '0;
                n_appr   = '0;
                n_slack  = '0;
                n_speed  = 1'b0;
                n_status = zsre_pkg::STAT_REFUSED;
                if (w_accept && (i_func == zsre_pkg::FUNC_TICK)) begin
                    n_tick      = r_tick + TW'(1);
                    n_tick_slot = step_slot(r_tick_slot, r_tick);
                    n_status    = zsre_pkg::STAT_TICKED;
                end else if (i_func == zsre_pkg::FUNC_RELEASE) begin
                    n_status = zsre_pkg::STAT_RELEASED;
                end
            end
            zsre_pkg::ST_REL_SCAN: begin
                n_rd_pend = 1'b1;
                n_rd_addr = r_addr;
                n_addr    = r_addr + AW'(1);
            end
            zsre_pkg::ST_RES_INIT: begin
                n_k      = r_earliest;
                n_cand_t = w_start_sum[TW-1:0];
                if (w_start_sum[TW]) begin
                    n_cand_slot = CW'(w_start_sum[OW-1:0]);
                end else begin
                    n_cand_slot = CW'(r_tick_slot) + CW'(r_earliest);
                end
            end
            zsre_pkg::ST_RES_NORM: begin
                if (w_norm_done) begin
                    n_walk_slot = SW'(r_cand_slot);
                    n_walk_t    = r_cand_t;
                    n_j         = '0;
                end else begin
                    n_cand_slot = r_cand_slot - SLOTS_C;
                end
            end
            zsre_pkg::ST_PROBE_CHK: begin
                if (w_slot_busy) begin
                    n_k         = r_k + OW'(1);
                    n_cand_t    = r_cand_t + TW'(1);
                    n_cand_slot = CW'(w_cand_step);
                    n_walk_t    = r_cand_t + TW'(1);
                    n_walk_slot = w_cand_step;
                    n_j         = '0;
                end else if (w_j_last) begin
                    n_walk_t    = r_cand_t;
                    n_walk_slot = SW'(r_cand_slot);
                    n_j         = '0;
                end else begin
                    n_walk_t    = r_walk_t + TW'(1);
                    n_walk_slot = w_walk_step;
                    n_j         = r_j + 3'd1;
                end
            end
            zsre_pkg::ST_CLAIM: begin
                n_walk_t    = r_walk_t + TW'(1);
                n_walk_slot = w_walk_step;
                n_j         = r_j + 3'd1;
                if (w_j_last) begin
                    n_status = zsre_pkg::STAT_GRANTED;
                    n_entry  = r_cand_t;
                    n_appr   = r_k;
                    n_slack  = r_latest - r_k;
                    n_speed  = (r_k > r_earliest);
                end
            end
            default: begin
                n_rd_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= zsre_pkg::ST_CLEAR;
            r_tick      <= '0;
            r_tick_slot <= '0;
            r_earliest  <= zsre_pkg::EARLIEST_RST;
            r_latest    <= zsre_pkg::LATEST_RST;
            r_addr      <= '0;
            r_rd_pend   <= 1'b0;
            r_j         <= '0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_tick_slot <= n_tick_slot;
            r_addr      <= n_addr;
            r_rd_pend   <= n_rd_pend;
            r_j         <= n_j;
            if (i_cfg_we && (i_cfg_index == zsre_pkg::CFG_EARLIEST)) begin
                r_earliest <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == zsre_pkg::CFG_LATEST)) begin
                r_latest <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id        <= n_id;
        r_len       <= n_len;
        r_zone0     <= n_zone0;
        r_zone1     <= n_zone1;
        r_zone2     <= n_zone2;
        r_k         <= n_k;
        r_cand_t    <= n_cand_t;
        r_cand_slot <= n_cand_slot;
        r_walk_t    <= n_walk_t;
        r_walk_slot <= n_walk_slot;
        r_rd_addr   <= n_rd_addr;
        r_status    <= n_status;
        r_entry     <= n_entry;
        r_appr      <= n_appr;
        r_slack     <= n_slack;
        r_speed     <= n_speed;
    end

    assign o_status         = r_status;
    assign o_entry_tick     = r_entry;
    assign o_approach_ticks = r_appr;
    assign o_slack_ticks    = r_slack;
    assign o_speed_mode     = r_speed;

    a_claim_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == zsre_pkg::ST_CLAIM) |-> (r_k >= r_earliest && r_k <= r_latest))
        else $error("claim outside offset window");

    a_step_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == zsre_pkg::ST_PROBE_RD || r_state == zsre_pkg::ST_CLAIM)
        |-> (r_j < 3'({r_len, 1'b0})))
        else $error("slot step beyond route");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == zsre_pkg::ST_PROBE_RD || r_state == zsre_pkg::ST_CLAIM)
        |-> (r_walk_slot <= LAST_SLOT && r_tick_slot <= LAST_SLOT))
        else $error("slot index out of range");

    a_grant_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == zsre_pkg::STAT_GRANTED)
        |-> (o_entry_tick == r_tick + TW'(o_approach_ticks)
             && o_speed_mode == (o_approach_ticks > r_earliest)))
        else $error("granted result inconsistent");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import zsre_pkg::*;

    localparam int SLOTS = 64;
    localparam int ZONES = 4;
    localparam int SLOT_IW = $clog2(SLOTS);
    localparam int ZONE_IW = $clog2(ZONES);
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 95;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   vehicle_id;
        logic [LEN_W-1:0]  route_len;
        logic [ZSEL_W-1:0] zone_first;
        logic [ZSEL_W-1:0] zone_second;
        logic [ZSEL_W-1:0] zone_third;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TICK_W-1:0] entry;
        logic [OFS_W-1:0]  approach;
        logic [OFS_W-1:0]  slack;
        logic              speed;
    } outcome_t;

    class zone_booking_board;
        logic [ID_W-1:0]  slot_owner [ZONES][SLOTS];
        logic [TICK_W-1:0] now_tick;
        logic [OFS_W-1:0] earliest;
        logic [OFS_W-1:0] latest;
        outcome_t         awaited [$];
        int               errors;

        function new();
            foreach (slot_owner[z, s]) slot_owner[z][s] = EMPTY_ID;
            now_tick = '0;
            earliest = EARLIEST_RST;
            latest = LATEST_RST;
            errors = 0;
        endfunction

        function void note_request(request_t r);
            outcome_t          o;
            logic [ZSEL_W-1:0] zone [3];
            logic [TICK_W-1:0] t;
            logic [TICK_W-1:0] slot;
            bit                found;
            bit                clear;
            int                k;
            o = '0;
            zone[0] = r.zone_first;
            zone[1] = r.zone_second;
            zone[2] = r.zone_third;
            case (r.func)
                FUNC_TICK: begin
                    now_tick = now_tick + 1;
                    o.status = STAT_TICKED;
                    awaited.push_back(o);
                end
                FUNC_RELEASE: begin
                    foreach (slot_owner[z, s])
                        if (slot_owner[z][s] == r.vehicle_id) slot_owner[z][s] = EMPTY_ID;
                    o.status = STAT_RELEASED;
                    awaited.push_back(o);
                end
                FUNC_RESERVE: begin
                    o.status = STAT_REFUSED;
                    found = 0;
                    if (r.route_len != 0) begin
                        for (k = int'(earliest); k <= int'(latest) && !found; k++) begin
                            t = now_tick + TICK_W'(k);
                            clear = 1;
                            for (int i = 0; i < int'(r.route_len); i++)
                                for (int d = 0; d < 2; d++) begin
                                    slot = t + TICK_W'(2 * i + d);
                                    if (slot_owner[ZONE_IW'(zone[i] % ZONES)]
                                                  [SLOT_IW'(slot % SLOTS)] != EMPTY_ID)
                                        clear = 0;
                                end
                            if (clear) begin
                                found = 1;
                                for (int i = 0; i < int'(r.route_len); i++)
                                    for (int d = 0; d < 2; d++) begin
                                        slot = t + TICK_W'(2 * i + d);
                                        slot_owner[ZONE_IW'(zone[i] % ZONES)]
                                                  [SLOT_IW'(slot % SLOTS)] = r.vehicle_id;
                                    end
                                o.status = STAT_GRANTED;
                                o.entry = t;
                                o.approach = OFS_W'(k);
                                o.slack = latest - OFS_W'(k);
                                o.speed = (k > int'(earliest));
                            end
                        end
                    end
                    awaited.push_back(o);
                end
                default: ;
            endcase
        endfunction

        function void check_result(outcome_t got);
            outcome_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, status %0d entry %0d", $time,
                         got.status, got.entry);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.entry !== want.entry) begin
                $display("%0t: entry_tick expected %0d actual %0d", $time, want.entry, got.entry);
                errors++;
            end
            if (got.approach !== want.approach) begin
                $display("%0t: approach_ticks expected %0d actual %0d", $time,
                         want.approach, got.approach);
                errors++;
            end
            if (got.slack !== want.slack) begin
                $display("%0t: slack_ticks expected %0d actual %0d", $time,
                         want.slack, got.slack);
                errors++;
            end
            if (got.speed !== want.speed) begin
                $display("%0t: speed_mode expected %0d actual %0d", $time,
                         want.speed, got.speed);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_IX_W-1:0] i_cfg_index;
    logic [OFS_W-1:0]  i_cfg_data;
    logic              i_valid;
    logic              o_stall;
    logic [FUNC_W-1:0] i_func;
    logic [ID_W-1:0]   i_vehicle_id;
    logic [LEN_W-1:0]  i_route_length;
    logic [ZSEL_W-1:0] i_zone_first;
    logic [ZSEL_W-1:0] i_zone_second;
    logic [ZSEL_W-1:0] i_zone_third;
    logic              o_valid;
    logic              i_stall;
    logic [STAT_W-1:0] o_status;
    logic [TICK_W-1:0] o_entry_tick;
    logic [OFS_W-1:0]  o_approach_ticks;
    logic [OFS_W-1:0]  o_slack_ticks;
    logic              o_speed_mode;

    zone_booking_board sb;
    bit quiet = 0;

    zone_slot_reservation_engine_top #(
        .SLOT_COUNT(SLOTS),
        .ZONE_COUNT(ZONES)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_func(i_func),
        .i_vehicle_id(i_vehicle_id),
        .i_route_length(i_route_length),
        .i_zone_first(i_zone_first),
        .i_zone_second(i_zone_second),
        .i_zone_third(i_zone_third),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_entry_tick(o_entry_tick),
        .o_approach_ticks(o_approach_ticks),
        .o_slack_ticks(o_slack_ticks),
        .o_speed_mode(o_speed_mode)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 16);
                i_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_status, o_entry_tick, o_approach_ticks, o_slack_ticks,
                             o_speed_mode});
    end

    function automatic request_t mk(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                    logic [LEN_W-1:0] len, logic [ZSEL_W-1:0] z1,
                                    logic [ZSEL_W-1:0] z2, logic [ZSEL_W-1:0] z3);
        request_t r;
        r = '{f, id, len, z1, z2, z3};
        return r;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) r.func = FUNC_TICK;
        else if (pick < 70) r.func = FUNC_RESERVE;
        else if (pick < 95) r.func = FUNC_RELEASE;
        else r.func = FUNC_UNUSED;
        if ($urandom_range(0, 9) == 0) r.vehicle_id = ID_W'($urandom_range(0, 255));
        else r.vehicle_id = ID_W'($urandom_range(0, 11));
        r.route_len = ($urandom_range(0, 19) == 0) ? 2'd0 : LEN_W'($urandom_range(1, 3));
        r.zone_first = ZSEL_W'($urandom_range(0, 3));
        r.zone_second = ZSEL_W'($urandom_range(0, 3));
        r.zone_third = ZSEL_W'($urandom_range(0, 3));
        return r;
    endfunction

    task automatic send_request(request_t r);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_func <= r.func;
        i_vehicle_id <= r.vehicle_id;
        i_route_length <= r.route_len;
        i_zone_first <= r.zone_first;
        i_zone_second <= r.zone_second;
        i_zone_third <= r.zone_third;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(r);
    endtask

    task automatic hold_off(int n);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        hold_off(1);
        while (sb.awaited.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_window(logic [OFS_W-1:0] e, logic [OFS_W-1:0] l);
        wait_drained();
        repeat (16) @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_EARLIEST;
        i_cfg_data <= e;
        @(negedge i_clk);
        i_cfg_index <= CFG_LATEST;
        i_cfg_data <= l;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.earliest = e;
        sb.latest = l;
    endtask

    initial begin
        int               e_list [PHASES];
        int               l_list [PHASES];
        int               waited;
        request_t         r;
        e_list = '{0, 0, 57, 57, 3, 10, 0, 0};
        l_list = '{57, 0, 57, 0, 12, 10, 0, 0};
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_func = '0;
        i_vehicle_id = '0;
        i_route_length = '0;
        i_zone_first = '0;
        i_zone_second = '0;
        i_zone_third = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(mk(FUNC_TICK, 0, 0, 0, 0, 0));
        send_request(mk(FUNC_RESERVE, 0, 1, 0, 0, 0));
        send_request(mk(FUNC_RESERVE, 1, 1, 0, 0, 0));
        send_request(mk(FUNC_RESERVE, 254, 3, 3, 2, 1));
        send_request(mk(FUNC_RESERVE, 255, 2, 0, 1, 0));
        send_request(mk(FUNC_RESERVE, 7, 0, 3, 3, 3));
        send_request(mk(FUNC_UNUSED, 9, 3, 1, 2, 3));
        send_request(mk(FUNC_RESERVE, 2, 3, 2, 2, 2));
        for (int id = 3; id < 9; id++) begin
            send_request(mk(FUNC_RESERVE, ID_W'(id), 1, 0, 0, 0));
            if (id == 5) hold_off($urandom_range(1, 16));
        end
        send_request(mk(FUNC_RELEASE, 0, 0, 0, 0, 0));
        send_request(mk(FUNC_RELEASE, 255, 3, 3, 3, 3));
        send_request(mk(FUNC_RELEASE, 254, 0, 0, 0, 0));
        send_request(mk(FUNC_RESERVE, 10, 3, 1, 2, 3));
        send_request(mk(FUNC_TICK, 255, 3, 3, 3, 3));
        send_request(mk(FUNC_TICK, 0, 0, 0, 0, 0));
        send_request(mk(FUNC_RELEASE, 1, 0, 0, 0, 0));
        send_request(mk(FUNC_RESERVE, 11, 2, 0, 3, 0));
        send_request(mk(FUNC_TICK, 0, 0, 0, 0, 0));

        e_list[6] = $urandom_range(0, 57);
        l_list[6] = $urandom_range(0, 57);
        e_list[7] = $urandom_range(0, 20);
        l_list[7] = $urandom_range(20, 57);
        for (int p = 0; p < PHASES; p++) begin
            set_window(OFS_W'(e_list[p]), OFS_W'(l_list[p]));
            if (p == PHASES - 1) quiet = 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = random_request();
                send_request(r);
                if (!quiet && n == PHASE_ITEMS / 2) wait_drained();
                else if (!quiet && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 16));
            end
        end

        hold_off(1);
        waited = 0;
        while (sb.awaited.size() != 0 && waited < 200_000) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.awaited.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.awaited.size());
            sb.errors++;
        end
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
